/* rtl/sieve_largest_prime_factor_defines.svh */
// Assertion macros for the sieve largest prime factor block
`ifndef SIEVE_LARGEST_PRIME_FACTOR_DEFINES_SVH
`define SIEVE_LARGEST_PRIME_FACTOR_DEFINES_SVH

// checked after reset is released
`define LPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LPF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/lpf_pkg.sv */
// Types, codes and defaults shared by the sieve largest prime factor block
package lpf_pkg;

    localparam int LPF_MAX_VALUE   = 65535;
    localparam int LPF_PRIME_DEPTH = 8192;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ONE     = 2'd1,
        ST_RANGE   = 2'd2,
        ST_NOBUILD = 2'd3
    } t_status;

    typedef struct packed {
        logic        op;
        logic [15:0] value;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] largest_factor;
        logic [14:0] other_multiples;
    } t_out_word;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLR_INIT,
        DP_CLR_STEP,
        DP_P_INIT,
        DP_P_RD,
        DP_P_CHK,
        DP_K_RD,
        DP_Q_MUL,
        DP_MARK,
        DP_K_INC,
        DP_P_INC,
        DP_Q_INIT,
        DP_REM_RD,
        DP_COMP_LATCH,
        DP_Q_LOAD,
        DP_DIV_REM,
        DP_REM_UPD,
        DP_DIV_LIM,
        DP_OUT_BUILD,
        DP_OUT_NB,
        DP_OUT_ONE,
        DP_OUT_RANGE,
        DP_OUT_OK
    } t_dp_op;

    typedef struct packed {
        logic is_query;
        logic built;
        logic val_one;
        logic val_bad;
        logic n_lt2;
        logic p_eq_n;
        logic map_bit;
        logic comp;
        logic k_ge_count;
        logic m_gt_n;
        logic div_done;
        logic div_rem_zero;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLR,
        S_PSTART,
        S_PRD,
        S_PCHK,
        S_KRD,
        S_QMUL,
        S_MARK,
        S_BDIV,
        S_NEXTP,
        S_QRD,
        S_QCOMP,
        S_QCHK,
        S_QLOAD,
        S_QDIV0,
        S_QDIV,
        S_IRD,
        S_ICOMP,
        S_IKINC,
        S_LDIV
    } t_state;

endpackage

/* rtl/lpf_ram.sv */
// Generic simple dual port RAM with registered read
module lpf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/lpf_div.sv */
// Iterative 16 bit restoring divider, one quotient bit per cycle
module lpf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quot,
    output logic [15:0] o_rem
);
    logic        r_busy, r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_rem, r_quo, r_dvs;
    logic [16:0] sh;
    logic        ge;
    logic [15:0] n_rem;

    always_comb begin
        sh    = {r_rem, r_quo[15]};
        ge    = sh >= {1'b0, r_dvs};
        n_rem = ge ? 16'(sh - {1'b0, r_dvs}) : sh[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[14:0], ge};
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule

/* rtl/lpf_dp.sv */
// Datapath: limit, sieve memories, counters, multiplier, divider and result register
module lpf_dp import lpf_pkg::*; #(
    parameter int MAX_VALUE   = LPF_MAX_VALUE,
    parameter int PRIME_DEPTH = LPF_PRIME_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_op    i_op,
    input  t_in_word  i_cmd,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output t_dp_stat  o_stat,
    output logic      o_done,
    output t_out_word o_result
);
    localparam int MAW = $clog2(MAX_VALUE + 1);
    localparam int PAW = $clog2(PRIME_DEPTH);
    localparam logic [31:0] MAXV = 32'(MAX_VALUE);
    localparam logic [PAW:0] PDEP = (PAW+1)'(PRIME_DEPTH);
    localparam logic [PAW:0] ONE_K = (PAW+1)'(1);

    logic [15:0]  r_limit, r_p, r_rem, r_q, r_value;
    logic         r_built, r_op, r_comp, r_done;
    logic [PAW:0] r_count, r_k;
    logic [31:0]  r_m;
    t_out_word    r_res;

    logic           map_we, map_wdata, map_rdata;
    logic [MAW-1:0] map_waddr, map_raddr;
    logic           list_we;
    logic [15:0]    list_rdata;
    logic           div_start, div_done;
    logic [15:0]    div_a, div_b, div_q, div_r;
    logic [15:0]    n_limit;

    always_comb begin
        n_limit   = (32'(i_cfg_data) > MAXV) ? MAXV[15:0] : i_cfg_data;
        map_we    = (i_op == DP_CLR_STEP) || (i_op == DP_MARK);
        map_waddr = (i_op == DP_MARK) ? MAW'(r_m) : MAW'(r_p);
        map_wdata = (i_op == DP_MARK) ? 1'b1 : (r_p < 16'd2);
        map_raddr = (i_op == DP_REM_RD) ? MAW'(r_rem) : MAW'(r_p);
        list_we   = (i_op == DP_P_CHK) && !map_rdata && (r_count < PDEP);
        div_start = (i_op == DP_MARK) || (i_op == DP_DIV_REM) || (i_op == DP_DIV_LIM);
        unique case (i_op)
            DP_MARK: begin
                div_a = r_p;
                div_b = r_q;
            end
            DP_DIV_LIM: begin
                div_a = r_limit;
                div_b = r_rem;
            end
            default: begin
                div_a = r_rem;
                div_b = r_q;
            end
        endcase
    end

    lpf_ram #(.WIDTH(1), .DEPTH(MAX_VALUE + 1)) u_map (
        .i_clk  (i_clk),
        .i_we   (map_we),
        .i_waddr(map_waddr),
        .i_wdata(map_wdata),
        .i_raddr(map_raddr),
        .o_rdata(map_rdata)
    );

    lpf_ram #(.WIDTH(16), .DEPTH(PRIME_DEPTH)) u_list (
        .i_clk  (i_clk),
        .i_we   (list_we),
        .i_waddr(r_count[PAW-1:0]),
        .i_wdata(r_p),
        .i_raddr(r_k[PAW-1:0]),
        .o_rdata(list_rdata)
    );

    lpf_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_a),
        .i_divisor (div_b),
        .o_done    (div_done),
        .o_quot    (div_q),
        .o_rem     (div_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= (32'hFFFF > MAXV) ? MAXV[15:0] : 16'hFFFF;
            r_built <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= n_limit;
                r_built <= 1'b0;
            end
            unique case (i_op)
                DP_LOAD: begin
                    r_op    <= i_cmd.op;
                    r_value <= i_cmd.value;
                end
                DP_CLR_INIT: begin
                    r_p     <= '0;
                    r_count <= '0;
                end
                DP_CLR_STEP: r_p <= r_p + 16'd1;
                DP_P_INIT:   r_p <= 16'd2;
                DP_P_CHK: begin
                    if (list_we) begin
                        r_count <= r_count + ONE_K;
                    end
                    r_k <= '0;
                end
                DP_Q_MUL: begin
                    r_q <= list_rdata;
                    r_m <= 32'(list_rdata) * 32'(r_p);
                end
                DP_K_INC: r_k <= r_k + ONE_K;
                DP_P_INC: r_p <= r_p + 16'd1;
                DP_Q_INIT: begin
                    r_rem <= r_value;
                    r_k   <= '0;
                end
                DP_COMP_LATCH: r_comp <= map_rdata;
                DP_Q_LOAD:     r_q <= list_rdata;
                DP_REM_UPD:    r_rem <= div_q;
                DP_OUT_BUILD: begin
                    r_built <= 1'b1;
                    r_done  <= 1'b1;
                    r_res   <= '{ST_OK, 16'd0, 15'd0};
                end
                DP_OUT_NB: begin
                    r_done <= 1'b1;
                    r_res  <= '{ST_NOBUILD, 16'd0, 15'd0};
                end
                DP_OUT_ONE: begin
                    r_done <= 1'b1;
                    r_res  <= '{ST_ONE, 16'd0, 15'd0};
                end
                DP_OUT_RANGE: begin
                    r_done <= 1'b1;
                    r_res  <= '{ST_RANGE, 16'd0, 15'd0};
                end
                DP_OUT_OK: begin
                    r_done <= 1'b1;
                    r_res  <= '{ST_OK, r_rem, 15'(div_q - 16'd1)};
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.is_query     = (r_op == OP_QUERY);
        o_stat.built        = r_built;
        o_stat.val_one      = (r_value == 16'd1);
        o_stat.val_bad      = (r_value == 16'd0) || (r_value > r_limit);
        o_stat.n_lt2        = (r_limit < 16'd2);
        o_stat.p_eq_n       = (r_p == r_limit);
        o_stat.map_bit      = map_rdata;
        o_stat.comp         = r_comp;
        o_stat.k_ge_count   = (r_k >= r_count);
        o_stat.m_gt_n       = (r_m > 32'(r_limit));
        o_stat.div_done     = div_done;
        o_stat.div_rem_zero = (div_r == 16'd0);
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

/* rtl/lpf_ctrl.sv */
// Controller state machine sequencing sieve builds and factor queries
module lpf_ctrl import lpf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = DP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (!i_stat.is_query) begin
                    o_op    = DP_CLR_INIT;
                    n_state = S_CLR;
                end else if (!i_stat.built) begin
                    o_op    = DP_OUT_NB;
                    n_state = S_IDLE;
                end else if (i_stat.val_one) begin
                    o_op    = DP_OUT_ONE;
                    n_state = S_IDLE;
                end else if (i_stat.val_bad) begin
                    o_op    = DP_OUT_RANGE;
                    n_state = S_IDLE;
                end else begin
                    o_op    = DP_Q_INIT;
                    n_state = S_QRD;
                end
            end
            S_CLR: begin
                o_op = DP_CLR_STEP;
                if (i_stat.p_eq_n) begin
                    n_state = S_PSTART;
                end
            end
            S_PSTART: begin
                if (i_stat.n_lt2) begin
                    o_op    = DP_OUT_BUILD;
                    n_state = S_IDLE;
                end else begin
                    o_op    = DP_P_INIT;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                o_op    = DP_P_RD;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                o_op    = DP_P_CHK;
                n_state = S_KRD;
            end
            S_KRD: begin
                if (i_stat.k_ge_count) begin
                    n_state = S_NEXTP;
                end else begin
                    o_op    = DP_K_RD;
                    n_state = S_QMUL;
                end
            end
            S_QMUL: begin
                o_op    = DP_Q_MUL;
                n_state = S_MARK;
            end
            S_MARK: begin
                if (i_stat.m_gt_n) begin
                    n_state = S_NEXTP;
                end else begin
                    o_op    = DP_MARK;
                    n_state = S_BDIV;
                end
            end
            S_BDIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.div_rem_zero) begin
                        n_state = S_NEXTP;
                    end else begin
                        o_op    = DP_K_INC;
                        n_state = S_KRD;
                    end
                end
            end
            S_NEXTP: begin
                if (i_stat.p_eq_n) begin
                    o_op    = DP_OUT_BUILD;
                    n_state = S_IDLE;
                end else begin
                    o_op    = DP_P_INC;
                    n_state = S_PRD;
                end
            end
            S_QRD: begin
                o_op    = DP_REM_RD;
                n_state = S_QCOMP;
            end
            S_QCOMP: begin
                o_op    = DP_COMP_LATCH;
                n_state = S_QCHK;
            end
            S_QCHK: begin
                if (!i_stat.comp || i_stat.k_ge_count) begin
                    o_op    = DP_DIV_LIM;
                    n_state = S_LDIV;
                end else begin
                    o_op    = DP_K_RD;
                    n_state = S_QLOAD;
                end
            end
            S_QLOAD: begin
                o_op    = DP_Q_LOAD;
                n_state = S_QDIV0;
            end
            S_QDIV0: begin
                o_op    = DP_DIV_REM;
                n_state = S_QDIV;
            end
            S_QDIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.div_rem_zero) begin
                        o_op    = DP_REM_UPD;
                        n_state = S_IRD;
                    end else begin
                        o_op    = DP_K_INC;
                        n_state = S_QCHK;
                    end
                end
            end
            S_IRD: begin
                o_op    = DP_REM_RD;
                n_state = S_ICOMP;
            end
            S_ICOMP: begin
                o_op    = DP_COMP_LATCH;
                n_state = i_stat.map_bit ? S_QDIV0 : S_IKINC;
            end
            S_IKINC: begin
                o_op    = DP_K_INC;
                n_state = S_QCHK;
            end
            S_LDIV: begin
                if (i_stat.div_done) begin
                    o_op    = DP_OUT_OK;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

/* rtl/sieve_largest_prime_factor.sv */
// Top level of the linear sieve largest prime factor block
//
//  channel  | handshake                  | word
//  ---------+----------------------------+------------------------------
//  command  | start / busy               | i_cmd      (t_in_word)
//  result   | o_done strobe, one cycle   | o_result   (t_out_word)
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (limit)
//
// Build: a clearing pass over the composite map for values 0 to limit, then each
// value from 2 is checked and its composites marked (16 step divider for p mod q).
// Query: the divider runs for each listed prime tried or factor divided out, then
// for limit / factor; special statuses answer without the divider.
// Reset has no clearing pass; the memories hold nothing valid until a build.
// The result strobe cannot be stalled; a new word may be taken in the strobe cycle.
module sieve_largest_prime_factor import lpf_pkg::*; #(
    parameter int MAX_VALUE   = LPF_MAX_VALUE,
    parameter int PRIME_DEPTH = LPF_PRIME_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_word    i_cmd,
    output logic        o_done,
    output t_out_word   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
`include "sieve_largest_prime_factor_defines.svh"

    t_dp_op   op;
    t_dp_stat stat;

    lpf_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_op   (op),
        .o_busy (busy)
    );

    lpf_dp #(.MAX_VALUE(MAX_VALUE), .PRIME_DEPTH(PRIME_DEPTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (op),
        .i_cmd     (i_cmd),
        .i_cfg_we  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .o_stat    (stat),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    assign o_cfg_ready = !busy;

    `LPF_ASSERT(a_start_busy, start && !busy |=> busy, "accepted word did not raise busy")
    `LPF_ASSERT(a_done_single, o_done |=> !o_done, "result strobe longer than one cycle")
    `LPF_ASSERT_ALWAYS(a_err_zero, o_done && o_result.status != ST_OK |-> o_result.largest_factor == 16'd0, "nonzero factor with error status")
endmodule
